// File: sv/epoch_seconds_to_calendar_core_macros.svh
// Assertion macros used by the calendar converter controller.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef EPOCH_SECONDS_TO_CALENDAR_CORE_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ESC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define ESC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/esc_pkg.sv
// Shared constants, command/status structs and the month length table
// for the epoch seconds to calendar converter. No dependencies.
package esc_pkg;

  // Default width of the seconds count
  localparam int unsigned SECONDS_WIDTH_DEF = 32;

  // Seconds in one common year and one leap year
  localparam logic [24:0] SECS_YEAR      = 25'd31536000;
  localparam logic [24:0] SECS_LEAP_YEAR = 25'd31622400;

  // Seconds in months of 31, 30, 29 and 28 days
  localparam logic [21:0] SECS_31_DAYS = 22'd2678400;
  localparam logic [21:0] SECS_30_DAYS = 22'd2592000;
  localparam logic [21:0] SECS_29_DAYS = 22'd2505600;
  localparam logic [21:0] SECS_28_DAYS = 22'd2419200;

  // Seconds in a day, an hour and a minute
  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

  // Reciprocals for the splits, exact over the ranges they see:
  // x / 86400 = ((x >> 7) * DAY_RECIP) >> 24 for x below 31 days
  localparam logic [14:0] DAY_RECIP  = 15'd24856;
  // x / 3600 = ((x >> 4) * HOUR_RECIP) >> 20 for x below one day
  localparam logic [12:0] HOUR_RECIP = 13'd4661;
  // x / 60 = ((x >> 2) * MIN_RECIP) >> 14 for x below one hour
  localparam logic [10:0] MIN_RECIP  = 11'd1093;

  // Calendar constants
  localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
  localparam logic [6:0]  EPOCH_MOD100 = 7'd70;
  localparam logic [8:0]  EPOCH_MOD400 = 9'd370;
  localparam logic [6:0]  LAST_MOD100  = 7'd99;
  localparam logic [8:0]  LAST_MOD400  = 9'd399;
  localparam logic [3:0]  LAST_MONTH   = 4'd11;

  // Steps that split the leftover seconds of the month
  typedef enum logic [2:0] {
    SPL_DAY  = 3'd0,
    SPL_SOD  = 3'd1,
    SPL_HOUR = 3'd2,
    SPL_SOH  = 3'd3,
    SPL_MIN  = 3'd4,
    SPL_SEC  = 3'd5
  } split_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       year_step;
    logic       month_step;
    logic       split_step;
    split_sel_t split_sel;
    logic       out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic year_done;
    logic month_done;
  } sts_t;

  // Seconds in month, month index 0 is January
  function automatic logic [21:0] month_secs(input logic [3:0] mon, input logic leap);
    logic [21:0] secs;
    case (mon) inside
      4'd1:                    secs = leap ? SECS_29_DAYS : SECS_28_DAYS;
      4'd3, 4'd5, 4'd8, 4'd10: secs = SECS_30_DAYS;
      default:                 secs = SECS_31_DAYS;
    endcase
    return secs;
  endfunction

endpackage

// File: sv/epoch_seconds_to_calendar_core.sv
// Top level of the epoch seconds to calendar converter: joins the
// controller and the datapath. Depends on esc_pkg, esc_ctrl, esc_datapath.
//
//   channel   handshake              fields
//   input     in_valid / in_stall    in_epoch_seconds[31:0]
//   output    out_valid / out_stall  out_year, out_month, out_day_of_month,
//                                    out_hour, out_minute, out_second
//
// Each item runs from its accept through a year-by-year subtract loop and a month loop,
// then six split steps and one output load, before the next item can be accepted.
// One item is in work at a time; the next is taken while a result waits in the output register.
// A stalled output holds the result; the finished item then waits until the register frees.
// Reset (rst_n, synchronous, active low) clears the sequencer and the output valid flag.
module epoch_seconds_to_calendar_core #(
  parameter int unsigned SECONDS_WIDTH = esc_pkg::SECONDS_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second
);

  esc_pkg::cmd_t cmd;
  esc_pkg::sts_t sts;

  // Sequencer
  esc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Calendar walk, splits and result registers
  esc_datapath #(
    .SECONDS_WIDTH(SECONDS_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .cmd             (cmd),
    .sts             (sts),
    .in_epoch_seconds(in_epoch_seconds),
    .out_year        (out_year),
    .out_month       (out_month),
    .out_day_of_month(out_day_of_month),
    .out_hour        (out_hour),
    .out_minute      (out_minute),
    .out_second      (out_second)
  );

endmodule

// File: sv/esc_datapath.sv
// Datapath of the calendar converter: year and month walk on the seconds
// count, reciprocal splits of the leftover, result registers. Depends on esc_pkg.
module esc_datapath #(
  parameter int unsigned SECONDS_WIDTH = esc_pkg::SECONDS_WIDTH_DEF
) (
  input  logic               clk,
  input  esc_pkg::cmd_t      cmd,
  output esc_pkg::sts_t      sts,
  input  logic [31:0]        in_epoch_seconds,
  output logic [11:0]        out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day_of_month,
  output logic [4:0]         out_hour,
  output logic [5:0]         out_minute,
  output logic [5:0]         out_second
);

  localparam int unsigned SW     = SECONDS_WIDTH;
  localparam int unsigned YC_W   = SW - 23;
  localparam int unsigned YEAR_W = ((YC_W > 11) ? YC_W : 11) + 1;

  // Working registers
  logic [SW-1:0]     secs_r;
  logic [YEAR_W-1:0] year_r;
  logic [6:0]        c100_r;
  logic [8:0]        c400_r;
  logic [3:0]        mon_r;
  logic [4:0]        mday_r;
  logic [16:0]       part_r;
  logic [4:0]        hour_r;
  logic [5:0]        minute_r;
  logic [5:0]        second_r;

  // Result registers
  logic [11:0] out_year_r;
  logic [3:0]  out_month_r;
  logic [4:0]  out_day_r;
  logic [4:0]  out_hour_r;
  logic [5:0]  out_minute_r;
  logic [5:0]  out_second_r;

  logic          leap;
  logic [SW-1:0] ylen;
  logic [SW-1:0] mlen;
  logic [28:0]   day_prod;
  logic [21:0]   day_base;
  logic [21:0]   sod_full;
  logic [24:0]   hour_prod;
  logic [16:0]   hour_base;
  logic [16:0]   soh_full;
  logic [19:0]   min_prod;
  logic [11:0]   min_base;
  logic [11:0]   sec_full;

  // Gregorian leap rule from year bits and the running century counters
  assign leap = (year_r[1:0] == 2'd0) &&
                ((c100_r != 7'd0) || (c400_r == 9'd0));
  assign ylen = SW'(leap ? esc_pkg::SECS_LEAP_YEAR : esc_pkg::SECS_YEAR);
  assign mlen = SW'(esc_pkg::month_secs(mon_r, leap));

  assign sts.year_done  = (secs_r < ylen);
  assign sts.month_done = (mon_r == esc_pkg::LAST_MONTH) || (secs_r < mlen);

  // Split the leftover of the month: quotient by reciprocal, then the remainder
  assign day_prod  = 29'(secs_r[21:7]) * 29'(esc_pkg::DAY_RECIP);
  assign day_base  = 22'(mday_r) * 22'(esc_pkg::SECS_PER_DAY);
  assign sod_full  = secs_r[21:0] - day_base;
  assign hour_prod = 25'(part_r[16:4]) * 25'(esc_pkg::HOUR_RECIP);
  assign hour_base = 17'(hour_r) * 17'(esc_pkg::SECS_PER_HOUR);
  assign soh_full  = part_r - hour_base;
  assign min_prod  = 20'(part_r[11:2]) * 20'(esc_pkg::MIN_RECIP);
  assign min_base  = 12'(minute_r) * 12'(esc_pkg::SECS_PER_MIN);
  assign sec_full  = part_r[11:0] - min_base;

  // Working register updates
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      secs_r <= SW'(in_epoch_seconds);
      year_r <= YEAR_W'(esc_pkg::EPOCH_YEAR);
      c100_r <= esc_pkg::EPOCH_MOD100;
      c400_r <= esc_pkg::EPOCH_MOD400;
      mon_r  <= '0;
    end
    // Consume one year of seconds
    if (cmd.year_step) begin
      secs_r <= secs_r - ylen;
      year_r <= year_r + YEAR_W'(1);
      c100_r <= (c100_r == esc_pkg::LAST_MOD100) ? 7'd0 : c100_r + 7'd1;
      c400_r <= (c400_r == esc_pkg::LAST_MOD400) ? 9'd0 : c400_r + 9'd1;
    end
    // Consume one month of seconds
    if (cmd.month_step) begin
      secs_r <= secs_r - mlen;
      mon_r  <= mon_r + 4'd1;
    end
    // Advance one split step
    if (cmd.split_step) begin
      unique case (cmd.split_sel)
        esc_pkg::SPL_DAY:  mday_r   <= day_prod[28:24];
        esc_pkg::SPL_SOD:  part_r   <= sod_full[16:0];
        esc_pkg::SPL_HOUR: hour_r   <= hour_prod[24:20];
        esc_pkg::SPL_SOH:  part_r   <= soh_full;
        esc_pkg::SPL_MIN:  minute_r <= min_prod[19:14];
        esc_pkg::SPL_SEC:  second_r <= sec_full[5:0];
        default:           part_r   <= part_r;
      endcase
    end
  end

  // Capture the finished result
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_year_r   <= year_r[11:0];
      out_month_r  <= mon_r + 4'd1;
      out_day_r    <= mday_r + 5'd1;
      out_hour_r   <= hour_r;
      out_minute_r <= minute_r;
      out_second_r <= second_r;
    end
  end

  assign out_year         = out_year_r;
  assign out_month        = out_month_r;
  assign out_day_of_month = out_day_r;
  assign out_hour         = out_hour_r;
  assign out_minute       = out_minute_r;
  assign out_second       = out_second_r;

endmodule

// File: sv/esc_ctrl.sv
// Controller of the calendar converter: one-hot sequencer over the year,
// month and split phases, plus the output valid flag. Depends on esc_pkg.
`include "epoch_seconds_to_calendar_core_macros.svh"

module esc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output esc_pkg::cmd_t cmd,
  input  esc_pkg::sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_YEAR  = 5'b00010,
    S_MONTH = 5'b00100,
    S_SPLIT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  esc_pkg::split_sel_t step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  // Output register can take a result when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  // Sequence the phases of one item
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_YEAR;
        end
      end
      S_YEAR: begin
        if (sts.year_done) begin
          state_nxt = S_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      S_MONTH: begin
        if (!sts.month_done) begin
          cmd.month_step = 1'b1;
        end else begin
          step_nxt  = esc_pkg::SPL_DAY;
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        cmd.split_step = 1'b1;
        cmd.split_sel  = step_r;
        if (step_r == esc_pkg::SPL_SEC) begin
          state_nxt = S_DONE;
        end else begin
          step_nxt = esc_pkg::split_sel_t'(step_r + 3'd1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= esc_pkg::SPL_DAY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `ESC_ASSERT_NXT(a_accept, in_valid && !in_stall, state_r == S_YEAR, "accepted item lost")
  `ESC_ASSERT_IMP(a_one_hot, 1'b1, $onehot(state_r), "state not one-hot")
  `ESC_ASSERT_IMP(a_no_overwrite, out_valid_r && out_stall, !cmd.out_load, "result overwritten")
  `ESC_ASSERT_NXT(a_load_valid, cmd.out_load, out_valid_r, "loaded result not valid")

endmodule
